// ===== design/dds_cws_pkg.sv =====
// shared constants, types and word table for the dds command word sequencer
`timescale 1ns / 1ps

package dds_cws_pkg;

	localparam int unsigned MCLK_MHZ_DEF = 25;

	// field widths
	localparam int unsigned SEL_W   = 2;
	localparam int unsigned FREQ_W  = 24;
	localparam int unsigned MODE_W  = 2;
	localparam int unsigned PHASE_W = 12;
	localparam int unsigned WORD_W  = 16;
	localparam int unsigned TW_W    = 28;
	localparam int unsigned HALF_W  = 14;
	localparam int unsigned IDX_W   = 4;

	// 1e6 = 2^6 * 15625
	localparam int unsigned HZ_POW2     = 6;
	localparam longint unsigned HZ_ODD  = 15625;

	// request codes
	localparam logic REQ_PROGRAM = 1'b0;
	localparam logic REQ_RESET   = 1'b1;

	// wave mode codes
	localparam logic [MODE_W-1:0] WAVE_TRI    = 2'd0;
	localparam logic [MODE_W-1:0] WAVE_SQUARE = 2'd1;
	localparam logic [MODE_W-1:0] WAVE_SINE   = 2'd2;
	localparam logic [MODE_W-1:0] WAVE_NONE   = 2'd3;

	// command words
	localparam logic [WORD_W-1:0] FREG0_TAG     = 16'h4000;
	localparam logic [WORD_W-1:0] FREG1_TAG     = 16'h8000;
	localparam logic [WORD_W-1:0] PHASE_TAG     = 16'hC000;
	localparam logic [WORD_W-1:0] CMD_RESET     = 16'h0100;
	localparam logic [WORD_W-1:0] CMD_B28_RESET = 16'h2100;
	localparam logic [WORD_W-1:0] CMD_TRI       = 16'h2002;
	localparam logic [WORD_W-1:0] CMD_SQUARE    = 16'h2028;
	localparam logic [WORD_W-1:0] CMD_SINE      = 16'h2000;

	localparam int unsigned RESET_LEN = 9;
	localparam logic [WORD_W-1:0] RESET_RUN [RESET_LEN] = '{
		16'h0100, 16'h2000, 16'h4000, 16'h4000, 16'h2000,
		16'h8000, 16'h8000, 16'hD000, 16'hF000
	};

	// word positions in a program run
	localparam logic [IDX_W-1:0] SLOT_RESET = 4'd0;
	localparam logic [IDX_W-1:0] SLOT_B28   = 4'd1;
	localparam logic [IDX_W-1:0] SLOT_LSB   = 4'd2;
	localparam logic [IDX_W-1:0] SLOT_MSB   = 4'd3;
	localparam logic [IDX_W-1:0] SLOT_PHASE = 4'd4;
	localparam logic [IDX_W-1:0] SLOT_MODE  = 4'd5;

	typedef struct packed {
		logic               req;
		logic [SEL_W-1:0]   sel;
		logic               freg;
		logic [MODE_W-1:0]  mode;
		logic [PHASE_W-1:0] phase;
	} cmd_t;

	function automatic logic [IDX_W-1:0] last_slot(input cmd_t c);
		logic [IDX_W-1:0] n;
		if (c.req == REQ_RESET) begin
			n = IDX_W'(RESET_LEN - 1);
		end else if (c.mode == WAVE_NONE) begin
			n = SLOT_PHASE;
		end else begin
			n = SLOT_MODE;
		end
		return n;
	endfunction

	function automatic logic [WORD_W-1:0] cmd_word(input cmd_t c,
			input logic [TW_W-1:0] tw, input logic [IDX_W-1:0] idx);
		logic [WORD_W-1:0] tag;
		logic [WORD_W-1:0] w;
		tag = (c.freg == 1'b0) ? FREG0_TAG : FREG1_TAG;
		w   = '0;
		if (c.req == REQ_RESET) begin
			if (idx < IDX_W'(RESET_LEN)) begin
				w = RESET_RUN[idx];
			end
		end else begin
			case (idx)
				SLOT_RESET: w = CMD_RESET;
				SLOT_B28:   w = CMD_B28_RESET;
				SLOT_LSB:   w = tag | WORD_W'(tw[HALF_W-1:0]);
				SLOT_MSB:   w = tag | WORD_W'(tw[2*HALF_W-1:HALF_W]);
				SLOT_PHASE: w = PHASE_TAG | WORD_W'(c.phase);
				SLOT_MODE: begin
					case (c.mode)
						WAVE_TRI:    w = CMD_TRI;
						WAVE_SQUARE: w = CMD_SQUARE;
						WAVE_SINE:   w = CMD_SINE;
						default:     w = CMD_SINE;
					endcase
				end
				default: w = '0;
			endcase
		end
		return w;
	endfunction

endpackage

// ===== design/dds_command_word_sequencer_unit.sv =====
// top level: tuning word pipeline and command word emitter
`timescale 1ns / 1ps

// Turns one request into its run of 16-bit command words for a DDS chip, one
// word per clock on spi_word/select_line with strobe high, last marking the
// final word. A reset request gives nine words, a program request six, or
// five when wave_shape is 3. The tuning word floor(freq_hz * 2^28 / clock) is
// computed by reciprocal multiplication in a four-stage pipeline (input,
// product, remainder, correction); the first word then passes the emitter's
// control and word registers. The word port sets the rate: a request holds it
// for its whole run, and runs follow each other with no gap if the next one
// already waits in the last stage. busy is high only while all stages hold a
// request waiting on the emitter; strobe cannot be held off by the receiver.
module dds_command_word_sequencer_unit
	import dds_cws_pkg::*;
#(
	parameter int unsigned MCLK_MHZ = MCLK_MHZ_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                req_type,
	input  logic [SEL_W-1:0]    chip_sel,
	input  logic [FREQ_W-1:0]   freq_hz,
	input  logic                freq_reg,
	input  logic [MODE_W-1:0]   wave_shape,
	input  logic [PHASE_W-1:0]  phase_val,
	output logic                strobe,
	output logic [WORD_W-1:0]   spi_word,
	output logic [SEL_W-1:0]    select_line,
	output logic                last
);

	// tuning word = (freq << (TW_W - 6)) / (MCLK_MHZ * 15625)
	localparam longint unsigned DIVISOR = longint'(MCLK_MHZ) * HZ_ODD;
	localparam longint unsigned RECIP =
		(64'd1 << (TW_W - HZ_POW2 + FREQ_W)) / DIVISOR;
	localparam int unsigned RECIP_W = $clog2(RECIP + 64'd1);
	localparam int unsigned PROD_W  = FREQ_W + RECIP_W;
	localparam int unsigned REM_W   = $clog2(DIVISOR) + 2;
	localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'(RECIP);
	localparam logic [REM_W-1:0]   DIV_K   = REM_W'(DIVISOR);

	logic accept;
	logic en1, en2, en3, en4, take_e;

	logic                valid_s1, valid_s2, valid_s3, valid_s4;
	cmd_t                cmd_s1, cmd_s2, cmd_s3, cmd_s4;
	logic [FREQ_W-1:0]   freq_s1;
	logic [PROD_W-1:0]   prod_s2;
	logic [TW_W-1:0]     qest_s3;
	logic [REM_W-1:0]    mrem_s3;
	logic [TW_W-1:0]     tw_s4;
	logic [REM_W-1:0]    rem;

	logic                active_q;
	logic [IDX_W-1:0]    idx_q;
	logic [IDX_W-1:0]    last_idx_q;
	cmd_t                cmd_q;
	logic [TW_W-1:0]     tw_q;
	logic                last_now;

	logic                strobe_q;
	logic                last_q;
	logic [WORD_W-1:0]   word_q;
	logic [SEL_W-1:0]    sel_out_q;

	// stall chain: a stage moves when it is empty or the next one moves
	assign last_now = (idx_q == last_idx_q);
	assign take_e   = !active_q || last_now;
	assign en4      = !valid_s4 || take_e;
	assign en3      = !valid_s3 || en4;
	assign en2      = !valid_s2 || en3;
	assign en1      = !valid_s1 || en2;
	assign busy     = !en1;
	assign accept   = start && en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= accept;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
			if (en4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && accept) begin
			cmd_s1  <= '{req: req_type, sel: chip_sel, freg: freq_reg,
			             mode: wave_shape, phase: phase_val};
			freq_s1 <= freq_hz;
		end
		if (en2) begin
			cmd_s2  <= cmd_s1;
			prod_s2 <= PROD_W'(freq_s1) * PROD_W'(RECIP_K);
		end
		if (en3) begin
			cmd_s3  <= cmd_s2;
			qest_s3 <= TW_W'(prod_s2 >> FREQ_W);
			// only the low bits of estimate * divisor matter for the remainder
			mrem_s3 <= REM_W'(REM_W'(prod_s2 >> FREQ_W) * DIV_K);
		end
		if (en4) begin
			cmd_s4 <= cmd_s3;
			tw_s4  <= qest_s3 + TW_W'(rem >= DIV_K);
		end
	end

	// dividend has its low bits zero, so remainder is minus the product
	assign rem = '0 - mrem_s3;

	// emitter control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			strobe_q <= active_q;
			last_q   <= active_q && last_now;
			if (take_e && valid_s4) begin
				active_q <= 1'b1;
				idx_q    <= '0;
			end else if (active_q) begin
				if (last_now) begin
					active_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	// emitter payload
	always_ff @(posedge clk) begin
		if (take_e && valid_s4) begin
			cmd_q      <= cmd_s4;
			tw_q       <= tw_s4;
			last_idx_q <= last_slot(cmd_s4);
		end
		if (active_q) begin
			word_q    <= cmd_word(cmd_q, tw_q, idx_q);
			sel_out_q <= cmd_q.sel;
		end
	end

	assign strobe      = strobe_q;
	assign spi_word    = word_q;
	assign select_line = sel_out_q;
	assign last        = last_q;

	a_last_needs_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last_q |-> strobe_q)
		else $error("last without strobe");

	a_run_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && !last_q |=> strobe_q)
		else $error("gap inside a word run");

	a_idx_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> idx_q <= last_idx_q)
		else $error("word index past end of run");

	a_busy_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> valid_s1 && valid_s2 && valid_s3 && valid_s4 && active_q)
		else $error("busy while pipeline has room");

endmodule

// ===== verif/tb_dds_command_word_sequencer_unit.sv =====
// testbench for the dds command word sequencer: directed and random requests, word-by-word check
`timescale 1ns / 1ps

module tb_dds_command_word_sequencer_unit
	import dds_cws_pkg::*;
();

	typedef struct {
		logic               req;
		logic [SEL_W-1:0]   sel;
		logic [FREQ_W-1:0]  freq;
		logic               freg;
		logic [MODE_W-1:0]  mode;
		logic [PHASE_W-1:0] phase;
		bit                 drain_first;
	} request_t;

	typedef struct {
		logic [WORD_W-1:0] word;
		logic [SEL_W-1:0]  sel;
		logic              last;
	} cmd_word_t;

	// fixed power-up sequence of the chip
	localparam logic [WORD_W-1:0] CHIP_INIT_RUN [9] = '{
		16'h0100, 16'h2000, 16'h4000, 16'h4000, 16'h2000,
		16'h8000, 16'h8000, 16'hD000, 16'hF000
	};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic                req_type = REQ_PROGRAM;
	logic [SEL_W-1:0]    chip_sel = '0;
	logic [FREQ_W-1:0]   freq_hz = '0;
	logic                freq_reg = 1'b0;
	logic [MODE_W-1:0]   wave_shape = WAVE_TRI;
	logic [PHASE_W-1:0]  phase_val = '0;
	logic                strobe;
	logic [WORD_W-1:0]   spi_word;
	logic [SEL_W-1:0]    select_line;
	logic                last;

	request_t  request_queue [$];
	cmd_word_t word_queue [$];
	request_t  cur_req;
	cmd_word_t got_word;
	logic      took = 1'b0;
	int        launched = 0;
	int        errors = 0;
	int        n_requests = 0;
	int        n_words = 0;
	int        n_init_runs = 0;
	int        n_short_runs = 0;

	dds_command_word_sequencer_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.chip_sel   (chip_sel),
		.freq_hz    (freq_hz),
		.freq_reg   (freq_reg),
		.wave_shape (wave_shape),
		.phase_val  (phase_val),
		.strobe     (strobe),
		.spi_word   (spi_word),
		.select_line(select_line),
		.last       (last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// expected command words for one accepted request
	task automatic predict_run(input logic req, input logic [SEL_W-1:0] sel,
			input logic [FREQ_W-1:0] freq, input logic freg,
			input logic [MODE_W-1:0] mode, input logic [PHASE_W-1:0] phase);
		logic [WORD_W-1:0] words [9];
		logic [WORD_W-1:0] tag;
		logic [TW_W-1:0]   tw;
		longint unsigned   num;
		int                n;
		cmd_word_t         w;
		n = 0;
		if (req == REQ_RESET) begin
			for (int i = 0; i < 9; i++) words[i] = CHIP_INIT_RUN[i];
			n = 9;
			n_init_runs++;
		end else begin
			num = longint'(freq) << 28;
			tw  = TW_W'(num / (longint'(MCLK_MHZ_DEF) * 64'd1000000));
			tag = freg ? FREG1_TAG : FREG0_TAG;
			words[0] = CMD_RESET;
			words[1] = CMD_B28_RESET;
			words[2] = tag | WORD_W'(tw[HALF_W-1:0]);
			words[3] = tag | WORD_W'(tw[TW_W-1:HALF_W]);
			words[4] = PHASE_TAG | WORD_W'(phase);
			n = 6;
			case (mode)
				WAVE_TRI:    words[5] = CMD_TRI;
				WAVE_SQUARE: words[5] = CMD_SQUARE;
				WAVE_SINE:   words[5] = CMD_SINE;
				default: begin
					n = 5;
					n_short_runs++;
				end
			endcase
		end
		for (int i = 0; i < n; i++) begin
			w.word = words[i];
			w.sel  = sel;
			w.last = (i == n - 1);
			word_queue.push_back(w);
		end
	endtask

	task automatic add_request(input logic req, input logic [SEL_W-1:0] sel,
			input logic [FREQ_W-1:0] freq, input logic freg,
			input logic [MODE_W-1:0] mode, input logic [PHASE_W-1:0] phase,
			input bit drain);
		request_t r;
		r.req = req;
		r.sel = sel;
		r.freq = freq;
		r.freg = freg;
		r.mode = mode;
		r.phase = phase;
		r.drain_first = drain;
		request_queue.push_back(r);
	endtask

	// driver: new request at the falling edge, held until a transfer
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && !took) begin
			// held off by busy
		end else if (request_queue.size() == 0
				|| (request_queue[0].drain_first && word_queue.size() != 0)
				|| (!(launched >= 120 && launched < 180) && $urandom_range(99) < 20)) begin
			start <= 1'b0;
		end else begin
			cur_req = request_queue.pop_front();
			req_type   <= cur_req.req;
			chip_sel   <= cur_req.sel;
			freq_hz    <= cur_req.freq;
			freq_reg   <= cur_req.freg;
			wave_shape <= cur_req.mode;
			phase_val  <= cur_req.phase;
			start      <= 1'b1;
			launched++;
		end
	end

	// monitor: check emitted words, then record a request transfer
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (word_queue.size() == 0) begin
				$error("unexpected word: spi_word %h select_line %0d last %b",
					spi_word, select_line, last);
				errors++;
			end else begin
				got_word = word_queue.pop_front();
				n_words++;
				if (spi_word !== got_word.word) begin
					$error("spi_word: expected %h, actual %h", got_word.word, spi_word);
					errors++;
				end
				if (select_line !== got_word.sel) begin
					$error("select_line: expected %0d, actual %0d", got_word.sel, select_line);
					errors++;
				end
				if (last !== got_word.last) begin
					$error("last: expected %b, actual %b", got_word.last, last);
					errors++;
				end
			end
		end
		if (arst_n && start && !busy) begin
			predict_run(req_type, chip_sel, freq_hz, freq_reg, wave_shape, phase_val);
			n_requests++;
		end
		took <= arst_n && start && !busy;
	end

	initial begin
		// directed: extremes, both requests, all wave modes
		add_request(REQ_RESET,   2'd1, 24'd0,        1'b0, WAVE_TRI,    12'h000, 1'b0);
		add_request(REQ_RESET,   2'd0, 24'hFFFFFF,   1'b1, WAVE_NONE,   12'hFFF, 1'b0);
		add_request(REQ_PROGRAM, 2'd1, 24'd0,        1'b0, WAVE_TRI,    12'h000, 1'b0);
		add_request(REQ_PROGRAM, 2'd2, 24'd12500000, 1'b1, WAVE_SQUARE, 12'hFFF, 1'b0);
		add_request(REQ_PROGRAM, 2'd3, 24'hFFFFFF,   1'b0, WAVE_SINE,   12'hAAA, 1'b0);
		add_request(REQ_PROGRAM, 2'd0, 24'd1,        1'b1, WAVE_NONE,   12'h555, 1'b1);
		add_request(REQ_PROGRAM, 2'd3, 24'd1000,     1'b0, WAVE_NONE,   12'hFFF, 1'b0);
		add_request(REQ_PROGRAM, 2'd1, 24'hAAAAAA,   1'b1, WAVE_TRI,    12'h123, 1'b0);
		add_request(REQ_PROGRAM, 2'd2, 24'h555555,   1'b0, WAVE_SINE,   12'hEDC, 1'b0);
		add_request(REQ_RESET,   2'd3, 24'h123456,   1'b0, WAVE_SINE,   12'h000, 1'b1);
		add_request(REQ_RESET,   2'd2, 24'd0,        1'b1, WAVE_SQUARE, 12'h800, 1'b0);
		add_request(REQ_PROGRAM, 2'd1, 24'd1000000,  1'b1, WAVE_SQUARE, 12'h000, 1'b0);
		add_request(REQ_PROGRAM, 2'd2, 24'd3,        1'b0, WAVE_TRI,    12'h001, 1'b0);
		add_request(REQ_PROGRAM, 2'd3, 24'd12499999, 1'b1, WAVE_NONE,   12'h7FF, 1'b0);
		add_request(REQ_PROGRAM, 2'd0, 24'h800000,   1'b0, WAVE_SINE,   12'h400, 1'b0);
		add_request(REQ_PROGRAM, 2'd1, 24'h7FFFFF,   1'b1, WAVE_TRI,    12'hBFF, 1'b0);
		for (int i = 0; i < 244; i++) begin
			request_t r;
			int pick;
			r.req   = ($urandom_range(99) < 15) ? REQ_RESET : REQ_PROGRAM;
			r.sel   = SEL_W'($urandom_range(3));
			pick    = $urandom_range(99);
			if (pick < 60)
				r.freq = FREQ_W'($urandom_range(12500000));
			else if (pick < 85)
				r.freq = FREQ_W'($urandom);
			else
				r.freq = FREQ_W'($urandom_range(1000));
			r.freg  = 1'($urandom_range(1));
			r.mode  = MODE_W'($urandom_range(3));
			r.phase = PHASE_W'($urandom);
			r.drain_first = (i % 50 == 25);
			request_queue.push_back(r);
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (request_queue.size() != 0 || start) @(posedge clk);
		while (word_queue.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);

		if (word_queue.size() != 0) begin
			$error("%0d expected words never emitted", word_queue.size());
			errors++;
		end
		$display("covered %0d requests (%0d reset runs, %0d runs without mode word)",
			n_requests, n_init_runs, n_short_runs);
		$display("checked %0d command words, %0d mismatches", n_words, errors);
		if (errors == 0) begin
			$display("dds_command_word_sequencer_unit verification clean");
		end else begin
			$display("dds_command_word_sequencer_unit verification failed");
		end
		$finish;
	end

	initial begin
		#1000000;
		$display("dds_command_word_sequencer_unit verification failed");
		$finish;
	end

endmodule
